FILE: design/asgr_pkg.sv
// Package for the ANSI SGR red/blue swap filter.
// Holds the byte codes, parse modes, burst type and the color index swap.
// No dependencies.
`timescale 1ns / 1ps

package asgr_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] LBRACKET   = 8'h5B;
    localparam logic [7:0] SEMICOLON  = 8'h3B;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_SEQ   = 2'd2;

    localparam logic [15:0] PARAM_MAX = 16'hFFFF;

    localparam int BURST_MAX = 6;
    localparam int LEN_W     = 3;
    localparam int DIGITS    = 5;

    localparam logic [15:0] FG_LO     = 16'd30;
    localparam logic [15:0] FG_HI     = 16'd37;
    localparam logic [15:0] BG_LO     = 16'd40;
    localparam logic [15:0] BG_HI     = 16'd47;
    localparam logic [15:0] FG_BR_LO  = 16'd90;
    localparam logic [15:0] FG_BR_HI  = 16'd97;
    localparam logic [15:0] BG_BR_LO  = 16'd100;
    localparam logic [15:0] BG_BR_HI  = 16'd107;

    typedef logic [7:0] t_byte;
    typedef logic [DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] data;
        logic [LEN_W-1:0]          len;
    } t_burst;

    // Exchanges bits 0 and 2 of a color index; bit 1 stays.
    function automatic logic [3:0] swap_ones(input logic [3:0] d);
        return {1'b0, d[0], d[1], d[2]};
    endfunction

endpackage

FILE: design/asgr_parse.sv
// Parser state and burst builder of the ANSI SGR red/blue swap filter.
// Keeps the parameter both in binary and in BCD; depends on asgr_pkg.
`timescale 1ns / 1ps

module asgr_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  asgr_pkg::t_byte i_byte,
    input  logic            i_accept,
    output asgr_pkg::t_burst o_burst
);
    import asgr_pkg::*;

    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_val,  n_val;
    t_bcd        r_bcd,  n_bcd;
    logic        r_seen, n_seen;

    logic [19:0]      acc;
    logic             sat;
    logic [3:0]       dig;
    logic             is_digit;
    logic             is_color;
    t_bcd             code_bcd;
    logic [LEN_W-1:0] code_w;
    logic [LEN_W-1:0] code_len;
    logic             tail_en;
    t_byte            tail;
    logic [LEN_W-1:0] idx;
    t_burst           burst;

    assign is_digit = (i_byte >= CHAR_0) && (i_byte <= CHAR_9);
    assign dig      = i_byte[3:0];
    assign acc      = ({4'd0, r_val} << 3) + ({4'd0, r_val} << 1) + {16'd0, dig};
    assign sat      = acc[19:16] != 4'd0;

    assign is_color = ((r_val >= FG_LO)    && (r_val <= FG_HI))
                   || ((r_val >= BG_LO)    && (r_val <= BG_HI))
                   || ((r_val >= FG_BR_LO) && (r_val <= FG_BR_HI))
                   || ((r_val >= BG_BR_LO) && (r_val <= BG_BR_HI));

    always_comb begin
        code_bcd = r_bcd;
        if (is_color) begin
            code_bcd[0] = swap_ones(r_bcd[0]);
        end
    end

    // Number of significant decimal digits, at least one.
    always_comb begin
        priority if (r_bcd[4] != 4'd0) begin
            code_w = 3'd5;
        end else if (r_bcd[3] != 4'd0) begin
            code_w = 3'd4;
        end else if (r_bcd[2] != 4'd0) begin
            code_w = 3'd3;
        end else if (r_bcd[1] != 4'd0) begin
            code_w = 3'd2;
        end else begin
            code_w = 3'd1;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_val    = r_val;
        n_bcd    = r_bcd;
        n_seen   = r_seen;
        code_len = '0;
        tail_en  = 1'b0;
        tail     = i_byte;
        burst    = '0;
        idx      = '0;

        unique case (r_mode)
            MODE_ESC: begin
                burst.data[0] = ESC_BYTE;
                if (i_byte == LBRACKET) begin
                    burst.data[1] = LBRACKET;
                    burst.len     = 3'd2;
                    n_mode        = MODE_SEQ;
                    n_val         = '0;
                    n_bcd         = '0;
                    n_seen        = 1'b0;
                end else if (i_byte == ESC_BYTE) begin
                    burst.len = 3'd1;
                end else begin
                    burst.data[1] = i_byte;
                    burst.len     = (i_byte != NUL_BYTE) ? 3'd2 : 3'd1;
                    n_mode        = MODE_PLAIN;
                end
            end
            MODE_SEQ: begin
                if (is_digit) begin
                    n_seen = 1'b1;
                    if (sat) begin
                        n_val = PARAM_MAX;
                        n_bcd = {4'd6, 4'd5, 4'd5, 4'd3, 4'd5};
                    end else begin
                        n_val = acc[15:0];
                        n_bcd = {r_bcd[3:0], dig};
                    end
                end else begin
                    if (i_byte == SEMICOLON) begin
                        code_len = code_w;
                        tail_en  = 1'b1;
                    end else begin
                        code_len = r_seen ? code_w : 3'd0;
                        tail_en  = i_byte != NUL_BYTE;
                        n_mode   = MODE_PLAIN;
                    end
                    n_val  = '0;
                    n_bcd  = '0;
                    n_seen = 1'b0;
                end
                // Code digits first, most significant first, then the tail byte.
                for (int j = 0; j < BURST_MAX; j++) begin
                    idx = 3'(code_len - 3'(j) - 3'd1);
                    if (3'(j) < code_len) begin
                        burst.data[j] = {4'h3, code_bcd[idx]};
                    end else begin
                        burst.data[j] = tail;
                    end
                end
                burst.len = code_len + {2'd0, tail_en};
            end
            default: begin
                // Plain text; the unused mode code behaves the same.
                n_mode        = (i_byte == ESC_BYTE) ? MODE_ESC : MODE_PLAIN;
                burst.data[0] = i_byte;
                burst.len     = ((i_byte != ESC_BYTE) && (i_byte != NUL_BYTE)) ? 3'd1 : 3'd0;
            end
        endcase
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_val  <= '0;
            r_bcd  <= '0;
            r_seen <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_bcd  <= n_bcd;
            r_seen <= n_seen;
        end
    end

endmodule

FILE: design/ansi_sgr_red_blue_swap_filter_top.sv
// Top level of the ANSI SGR red/blue swap filter.
// Instantiates asgr_parse and holds the output burst register; uses asgr_pkg.
`timescale 1ns / 1ps

// The block rewrites a terminal byte stream. Input bytes arrive as beats on
// the i_in_valid / o_in_ready channel; rewritten bytes leave as beats on the
// o_out_valid / i_out_ready channel, with o_last high on the final byte that
// one input byte produced. An input byte yields zero to six output bytes.
//
// Each accepted input byte is parsed as it is taken: the parser updates
// its mode and parameter registers and builds the whole burst of output
// bytes, which is loaded into the burst register. The first output byte is
// visible in the cycle after the input beat. The burst register drains one
// byte per cycle while the receiver is ready, so input runs at one byte per
// cycle while bursts hold one byte; a longer burst holds the next input.
// A new input beat is taken in the same cycle that the last byte of the
// previous burst is taken. A byte with no output waits for that drain like
// any other byte, and once taken it leaves the burst register empty.
//
// When the receiver stalls, the pending byte holds on o_out_byte and input
// beats wait once the burst register is full. Synchronous reset puts the
// parser back in plain text mode with an empty parameter and empties the
// burst register; no output beat is presented after reset.

module ansi_sgr_red_blue_swap_filter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import asgr_pkg::*;

    t_burst                    burst;
    logic [BURST_MAX-1:0][7:0] r_data;
    logic [LEN_W-1:0]          r_len;
    logic [LEN_W-1:0]          r_idx;
    logic                      at_last;
    logic                      in_fire;
    logic                      out_fire;

    asgr_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_in_byte),
        .i_accept (in_fire),
        .o_burst  (burst)
    );

    // The burst register is empty when its length is zero.
    assign o_out_valid = r_len != '0;
    assign at_last     = r_idx == (r_len - 3'd1);
    assign out_fire    = o_out_valid && i_out_ready;

    // Room for a new burst when empty, or when the last byte leaves now.
    assign o_in_ready  = (r_len == '0) || (i_out_ready && at_last);
    assign in_fire     = i_in_valid && o_in_ready;

    assign o_out_byte  = r_data[r_idx];
    assign o_last      = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_idx <= '0;
        end else if (in_fire) begin
            r_len <= burst.len;
            r_idx <= '0;
        end else if (out_fire) begin
            if (at_last) begin
                r_len <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Payload of the burst register needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data <= burst.data;
        end
    end

endmodule

FILE: tb/sgr_rewrite_checker.sv
// Checker for the SGR red/blue swap filter: predicts the rewritten stream and compares beats.
// Depends on asgr_pkg for byte codes, parse modes and color code ranges.
`timescale 1ns / 1ps

module sgr_rewrite_checker
    import asgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_out_beat;

    t_out_beat   expected_bytes[$];
    t_byte       step_bytes[$];
    logic [1:0]  mode_q;
    logic [15:0] code_q;
    logic        have_digit_q;

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        o_fail_count++;
        if (o_fail_count <= 30) begin
            $display("mismatch at %0t ns: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    // Exchanges bits 0 and 2 of the color index for the four color code ranges.
    function automatic logic [15:0] swap_red_blue(input logic [15:0] code);
        logic [15:0] base;
        logic [15:0] idx;
        if (code >= FG_LO && code <= FG_HI) begin
            base = FG_LO;
        end else if (code >= BG_LO && code <= BG_HI) begin
            base = BG_LO;
        end else if (code >= FG_BR_LO && code <= FG_BR_HI) begin
            base = FG_BR_LO;
        end else if (code >= BG_BR_LO && code <= BG_BR_HI) begin
            base = BG_BR_LO;
        end else begin
            return code;
        end
        idx = code - base;
        return base + {13'd0, idx[0], idx[1], idx[2]};
    endfunction

    function automatic void add_code(input logic [15:0] code);
        logic [15:0] v;
        t_byte       digs[$];
        v = swap_red_blue(code);
        do begin
            digs.push_front(CHAR_0 + t_byte'(v % 16'd10));
            v = v / 16'd10;
        end while (v != 0);
        foreach (digs[k]) step_bytes.push_back(digs[k]);
    endfunction

    function automatic void predict_rewrite(input t_byte b);
        int unsigned acc;
        step_bytes.delete();
        case (mode_q)
            MODE_ESC: begin
                step_bytes.push_back(ESC_BYTE);
                if (b == LBRACKET) begin
                    step_bytes.push_back(LBRACKET);
                    mode_q       = MODE_SEQ;
                    code_q       = '0;
                    have_digit_q = 1'b0;
                end else if (b != ESC_BYTE) begin
                    if (b != NUL_BYTE) step_bytes.push_back(b);
                    mode_q = MODE_PLAIN;
                end
            end
            MODE_SEQ: begin
                if (b >= CHAR_0 && b <= CHAR_9) begin
                    acc = int'(code_q) * 10 + int'(b - CHAR_0);
                    if (acc > int'(PARAM_MAX)) acc = int'(PARAM_MAX);
                    code_q       = acc[15:0];
                    have_digit_q = 1'b1;
                end else if (b == SEMICOLON) begin
                    add_code(code_q);
                    step_bytes.push_back(SEMICOLON);
                    code_q       = '0;
                    have_digit_q = 1'b0;
                end else begin
                    if (have_digit_q) add_code(code_q);
                    if (b != NUL_BYTE) step_bytes.push_back(b);
                    mode_q       = MODE_PLAIN;
                    code_q       = '0;
                    have_digit_q = 1'b0;
                end
            end
            default: begin
                mode_q = MODE_PLAIN;
                if (b == ESC_BYTE) begin
                    mode_q = MODE_ESC;
                end else if (b != NUL_BYTE) begin
                    step_bytes.push_back(b);
                end
            end
        endcase
        foreach (step_bytes[k]) begin
            expected_bytes.push_back('{data: step_bytes[k], last: (k == step_bytes.size() - 1)});
        end
    endfunction

    // Output beats at an edge come from earlier input beats, so compare before predicting.
    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            mode_q       = MODE_PLAIN;
            code_q       = '0;
            have_digit_q = 1'b0;
            expected_bytes.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report("unexpected output beat", 8'h00, i_out_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.data) report("out_byte", want.data, i_out_byte);
                    if (i_last !== want.last) report("last", {7'd0, want.last}, {7'd0, i_last});
                end
            end
            if (i_in_valid && i_in_ready) predict_rewrite(i_in_byte);
        end
        o_pending = expected_bytes.size();
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the SGR red/blue swap filter: clock, reset, byte stimulus and verdict.
// Depends on asgr_pkg, the filter top level and sgr_rewrite_checker.
`timescale 1ns / 1ps

module tb;
    import asgr_pkg::*;

    // Final byte of a select graphic rendition sequence.
    localparam t_byte CHAR_M = 8'h6D;

    // Ways the receiver takes output beats.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_LIGHT,
        RX_CADENCE
    } t_rx_style;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_byte i_in_byte   = '0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    logic  [7:0] o_out_byte;
    logic  o_last;

    int        fail_count;
    int        pending;
    logic      in_took   = 1'b0;
    t_rx_style rx_style  = RX_ALWAYS;
    bit        want_hold = 1'b0;
    int        max_gap   = 0;
    t_byte     stream[$];
    int        color_base[4] = '{30, 40, 90, 100};

    ansi_sgr_red_blue_swap_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    sgr_rewrite_checker rewrite_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Records whether the input beat was taken at the last rising edge. The
    // sender looks at this at the following falling edge, which keeps it
    // clear of any ordering question inside the rising edge time step.
    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_in_valid && o_in_ready;
    end

    // The receiver changes i_out_ready at falling edges only. Once the
    // stimulus asks for it, it holds off for a long stretch that it counts
    // itself; the sender keeps offering bytes meanwhile, so the burst
    // register fills and the block has to drop o_in_ready.
    initial begin : receiver
        int tick;
        int hold_left;
        bit hold_done;
        tick      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (want_hold && !hold_done) begin
                hold_left = 120;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                case (rx_style)
                    RX_ALWAYS: i_out_ready = 1'b1;
                    RX_COIN:   i_out_ready = ($urandom_range(0, 1) != 0);
                    RX_LIGHT:  i_out_ready = ($urandom_range(0, 3) != 0);
                    default:   i_out_ready = ((tick % 5) < 2);
                endcase
            end
        end
    end

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) stream.push_back(t_byte'(s[k]));
    endtask

    // A well formed SGR sequence with random parameters. Most end in 'm',
    // the rest are cut short by a zero byte, an ESC or some other byte.
    task automatic add_sgr();
        int    nparams;
        int    pick;
        int    v;
        string s;
        stream.push_back(ESC_BYTE);
        stream.push_back(LBRACKET);
        nparams = $urandom_range(1, 4);
        for (int p = 0; p < nparams; p++) begin
            if (p > 0) stream.push_back(SEMICOLON);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                s = "";
            end else if (pick <= 4) begin
                v = color_base[$urandom_range(0, 3)] + $urandom_range(0, 7);
                s = $sformatf("%0d", v);
            end else if (pick == 5) begin
                // Just outside a color range, so no swap may happen.
                v = color_base[$urandom_range(0, 3)] + ($urandom_range(0, 1) ? 8 : -1);
                s = $sformatf("%0d", v);
            end else if (pick <= 8) begin
                s = $sformatf("%0d", $urandom_range(0, 255));
            end else begin
                s = $sformatf("%0d", $urandom_range(1000, 999999));
            end
            if ($urandom_range(0, 7) == 0) s = {"0", s};
            add_text(s);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            stream.push_back(CHAR_M);
        end else if (pick == 7) begin
            stream.push_back(NUL_BYTE);
        end else if (pick == 8) begin
            stream.push_back(ESC_BYTE);
        end else begin
            // Anything from '<' upward is neither a digit nor a separator.
            stream.push_back(t_byte'($urandom_range(8'h3C, 8'hFF)));
        end
    endtask

    // Plain text and noise: any byte value, zero bytes and stray ESCs.
    task automatic add_noise();
        int n;
        int pick;
        n = $urandom_range(1, 6);
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                stream.push_back(t_byte'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 8) begin
                stream.push_back(t_byte'($urandom_range(0, 255)));
            end else if (pick == 8) begin
                stream.push_back(NUL_BYTE);
            end else begin
                stream.push_back(ESC_BYTE);
            end
        end
    endtask

    // Sends the queued bytes in bursts of random length. Between bursts the
    // valid line drops for a random gap of up to max_gap; with max_gap at
    // zero the bytes go back to back.
    task automatic send_stream();
        int burst_left;
        int gap;
        burst_left = 0;
        while (stream.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
                if (gap > 0) begin
                    i_in_valid = 1'b0;
                    i_in_byte  = t_byte'($urandom);
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_in_valid = 1'b1;
            i_in_byte  = stream.pop_front();
            do @(negedge i_clk); while (!in_took);
            burst_left--;
        end
        i_in_valid = 1'b0;
    endtask

    initial begin : stimulus
        int phase;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part. Plain bytes at the value extremes and a zero byte
        // in plain text, which produces nothing.
        rx_style = RX_LIGHT;
        max_gap  = 2;
        add_text("A");
        stream.push_back(NUL_BYTE);
        stream.push_back(8'hFF);
        stream.push_back(8'h80);
        // A held ESC followed by something other than '[' goes out raw, and
        // a second ESC takes the place of the first before '[' arrives.
        stream.push_back(ESC_BYTE);
        add_text("x");
        stream.push_back(ESC_BYTE);
        stream.push_back(ESC_BYTE);
        add_text("[31;;");
        // Six nines saturate the parameter; 65535 and 'm' make the longest
        // burst of six output bytes.
        add_text("999999");
        stream.push_back(CHAR_M);
        // A zero byte while ESC is held releases the ESC.
        stream.push_back(ESC_BYTE);
        stream.push_back(NUL_BYTE);
        // A zero byte inside a sequence flushes the pending code.
        stream.push_back(ESC_BYTE);
        add_text("[47");
        stream.push_back(NUL_BYTE);
        // An empty code before 'm' gives only the 'm'.
        stream.push_back(ESC_BYTE);
        add_text("[m");
        // Some other byte ends the sequence and passes through.
        stream.push_back(ESC_BYTE);
        add_text("[104q");
        send_stream();

        // Random part in four phases with different receiver behavior and
        // sender gaps. The first phase runs with no idling at all; the third
        // one carries the long receiver hold-off.
        for (phase = 0; phase < 4; phase++) begin
            rx_style = t_rx_style'(phase);
            case (phase)
                0:       max_gap = 0;
                1:       max_gap = 4;
                2:       max_gap = 2;
                default: max_gap = 6;
            endcase
            if (phase == 2) want_hold = 1'b1;
            while (stream.size() < 70) begin
                if ($urandom_range(0, 9) < 7) begin
                    add_sgr();
                end else begin
                    add_noise();
                end
            end
            send_stream();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS ansi_sgr_red_blue_swap_filter_top");
        end else begin
            $display("FAIL ansi_sgr_red_blue_swap_filter_top");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every byte stalled.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL ansi_sgr_red_blue_swap_filter_top");
        $finish;
    end

endmodule

FILE: sim.f
design/asgr_pkg.sv
design/asgr_parse.sv
design/ansi_sgr_red_blue_swap_filter_top.sv
tb/sgr_rewrite_checker.sv
tb/tb.sv
